// ===== design/bda_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
`default_nettype none
package bda_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_BITS = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_BITS;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_t;

endpackage
`default_nettype wire

// ===== design/bda_dabble.sv =====
// Bit-serial shift-and-add-3 binary to BCD converter, one bit per cycle.
`default_nettype none
module bda_dabble (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic                             neg,
  input  wire logic [bda_pkg::VALUE_BITS-1:0]   mag,
  output logic                                  busy,
  output logic                                  done,
  output bda_pkg::conv_t                        result
);

  logic [bda_pkg::VALUE_BITS-1:0] bin_r;
  logic [bda_pkg::BCD_W-1:0]      bcd_r;
  logic [bda_pkg::BCD_W-1:0]      adj;
  logic [bda_pkg::CNT_W-1:0]      cnt_r;
  logic                           run_r;
  logic                           done_r;
  logic                           neg_r;

  always_comb begin
    for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[i*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS] >= 4'd5) begin
        adj[i*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS] =
          bcd_r[i*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS] + 4'd3;
      end else begin
        adj[i*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS] =
          bcd_r[i*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        bin_r <= mag;
        bcd_r <= '0;
        cnt_r <= '0;
        neg_r <= neg;
        run_r <= 1'b1;
      end else if (run_r) begin
        {bcd_r, bin_r} <= {adj[bda_pkg::BCD_W-2:0], bin_r, 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == bda_pkg::CNT_W'(bda_pkg::VALUE_BITS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy       = run_r | done_r;
  assign done       = done_r;
  assign result.neg = neg_r;
  assign result.bcd = bcd_r;

endmodule
`default_nettype wire

// ===== design/bda_emit.sv =====
// Character sequencer: sign, then significant digits, through an output register.
`default_nettype none
module bda_emit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire bda_pkg::conv_t conv,
  output logic                busy,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_character,
  output logic                out_last
);

  logic [bda_pkg::BCD_W-1:0] bcd_r;
  logic [bda_pkg::IDX_W-1:0] idx_r;
  logic [bda_pkg::IDX_W-1:0] msd;
  logic                      neg_r;
  logic                      act_r;
  logic                      out_valid_r;
  logic [7:0]                out_character_r;
  logic                      out_last_r;
  logic                      take;
  logic [3:0]                digit;

  always_comb begin
    msd = '0;
    for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
      if (conv.bcd[i*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS] != 4'd0) begin
        msd = bda_pkg::IDX_W'(i);
      end
    end
  end

  assign take  = !out_valid_r || !out_stall;
  assign digit = bcd_r[idx_r*bda_pkg::DIGIT_BITS +: bda_pkg::DIGIT_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      neg_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= act_r;
      end
      if (load) begin
        bcd_r <= conv.bcd;
        neg_r <= conv.neg;
        idx_r <= msd;
        act_r <= 1'b1;
      end else if (act_r && take) begin
        if (neg_r) begin
          out_character_r <= bda_pkg::CHAR_MINUS;
          out_last_r      <= 1'b0;
          neg_r           <= 1'b0;
        end else begin
          out_character_r <= bda_pkg::CHAR_ZERO + {4'd0, digit};
          out_last_r      <= (idx_r == '0);
          if (idx_r == '0) begin
            act_r <= 1'b0;
          end else begin
            idx_r <= idx_r - 1'b1;
          end
        end
      end
    end
  end

  assign busy          = act_r;
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule
`default_nettype wire

// ===== design/binary_to_decimal_ascii_top.sv =====
// Top level of the binary word to decimal ASCII text converter.
// Input channel: in_valid/in_stall carry one request of in_func (0 unsigned,
// 1 two's complement) and the 32-bit in_value.
// Output channel: out_valid/out_stall carry each request's ASCII characters on
// out_character, with out_last high on the final character of the number.
// A negative signed value gives a leading '-'; leading zeros are dropped and
// zero gives a single '0'. The most negative value converts correctly.
// Conversion is a bit-serial shift-and-add-3 loop, one input bit per cycle,
// after which the digits are handed to the character sequencer. After the
// first character the rest follow one per cycle while out_stall is low. The
// next request is taken once the last character sits in the output register;
// a number has 1 to 11 characters.
// in_stall stays high while a number is in work.
// When out_stall is high the output register holds its character and the
// sequencer waits; no character is lost or repeated.
// Synchronous active-low reset empties the converter and the output register.
`default_nettype none
module binary_to_decimal_ascii_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_character,
  output logic             out_last
);

  logic                               start;
  logic                               neg;
  logic [bda_pkg::VALUE_BITS-1:0]     mag;
  logic                               dab_busy;
  logic                               dab_done;
  logic                               emit_busy;
  bda_pkg::conv_t                     conv;

  assign in_stall = dab_busy | emit_busy;
  assign start    = in_valid & !in_stall;
  assign neg      = in_func & in_value[bda_pkg::VALUE_BITS-1];
  assign mag      = neg ? (~in_value + 32'd1) : in_value;

  bda_dabble u_dabble (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .neg    (neg),
    .mag    (mag),
    .busy   (dab_busy),
    .done   (dab_done),
    .result (conv)
  );

  bda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (dab_done),
    .conv          (conv),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire

// ===== sim/tb_binary_to_decimal_ascii_top.sv =====
// Self-checking testbench for the binary word to decimal ASCII text converter.
`timescale 1ns / 100ps
module tb_binary_to_decimal_ascii_top;

  typedef struct {
    logic        func;
    logic [31:0] value;
  } num_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_character;
  logic        out_last;

  num_req_t   pending_reqs[$];
  text_char_t expected_chars[$];
  num_req_t   next_req;
  text_char_t want_char;
  longint     pow10[11];

  logic in_accepted;
  int   in_gap;
  int   stall_left;
  int   error_count;
  int   numbers_done;
  int   negatives_done;
  int   chars_seen;

  binary_to_decimal_ascii_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("tb: ERROR at %0t: %s", $realtime, msg);
  endtask

  // Decimal text of one number, sign first, most significant digit next.
  task automatic predict_text(input logic func, input logic [31:0] value);
    logic       neg;
    logic [31:0] mag;
    logic [3:0] digits[bda_pkg::MAX_DIGITS];
    int         cnt;
    text_char_t c;
    neg = func && value[31];
    mag = neg ? (~value + 32'd1) : value;
    cnt = 0;
    do begin
      digits[cnt] = 4'(mag % 32'd10);
      cnt++;
      mag = mag / 32'd10;
    end while (mag != 0 && cnt < bda_pkg::MAX_DIGITS);
    if (neg) begin
      c.ch = bda_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
      negatives_done++;
    end
    for (int k = cnt - 1; k >= 0; k--) begin
      c.ch = bda_pkg::CHAR_ZERO + {4'd0, digits[k]};
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
    numbers_done++;
  endtask

  task automatic add_req(input logic func, input logic [31:0] value);
    num_req_t r;
    r.func = func;
    r.value = value;
    pending_reqs.push_back(r);
  endtask

  // Request side: sample acceptance at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_text(in_func, in_value);
      in_accepted <= 1'b1;
    end else begin
      in_accepted <= 1'b0;
    end
  end

  // Driver: holds a request until taken; random idle bursts except in quiet stretches.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_accepted)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_reqs.size() >= 50 && (pending_reqs.size() / 40) % 3 != 1 &&
                   $urandom_range(0, 99) < 25) begin
        in_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else begin
        next_req = pending_reqs.pop_front();
        in_func <= next_req.func;
        in_value <= next_req.value;
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver stall bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (pending_reqs.size() >= 50 && (chars_seen / 48) % 3 != 2 &&
                   $urandom_range(0, 99) < 20) begin
        stall_left <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compare each character with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        note_error($sformatf("unexpected character %h last %b", out_character, out_last));
      end else begin
        want_char = expected_chars.pop_front();
        if (out_character !== want_char.ch || out_last !== want_char.last)
          note_error($sformatf("character exp %h last %b, got %h last %b",
                               want_char.ch, want_char.last, out_character, out_last));
      end
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic        f;
    logic [31:0] v;
    int          d;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = 1'b0;
    in_value = 32'd0;
    out_stall = 1'b0;
    in_accepted = 1'b0;
    in_gap = 0;
    stall_left = 0;
    error_count = 0;
    numbers_done = 0;
    negatives_done = 0;
    chars_seen = 0;
    pow10[0] = 1;
    for (int i = 1; i < 11; i++) pow10[i] = pow10[i-1] * 10;

    // directed: zero, digit boundaries, full range, most negative
    add_req(1'b0, 32'd0);
    add_req(1'b0, 32'd1);
    add_req(1'b0, 32'd9);
    add_req(1'b0, 32'd10);
    add_req(1'b0, 32'd99);
    add_req(1'b0, 32'd100);
    add_req(1'b0, 32'd999999999);
    add_req(1'b0, 32'd1000000000);
    add_req(1'b0, 32'hFFFFFFFF);
    add_req(1'b0, 32'h80000000);
    add_req(1'b0, 32'h7FFFFFFF);
    add_req(1'b1, 32'd0);
    add_req(1'b1, 32'd1);
    add_req(1'b1, 32'd123);
    add_req(1'b1, 32'hFFFFFFFF);
    add_req(1'b1, 32'h80000000);
    add_req(1'b1, 32'h80000001);
    add_req(1'b1, 32'h7FFFFFFF);
    add_req(1'b1, -32'sd9);
    add_req(1'b1, -32'sd10);
    add_req(1'b1, -32'sd1000000000);
    add_req(1'b1, 32'hAAAAAAAA);
    add_req(1'b0, 32'h55555555);

    for (int n = 0; n < 387; n++) begin
      f = 1'($urandom_range(0, 1));
      d = $urandom_range(0, 10);
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1: v = 32'(longint'($urandom) % pow10[d]);
        2: v = 32'(pow10[d % 10] + $urandom_range(0, 2) - 1);
        3: v = $urandom >> $urandom_range(0, 31);
        default: begin
          case ($urandom_range(0, 4))
            0: v = 32'd0;
            1: v = 32'hFFFFFFFF;
            2: v = 32'h80000000;
            3: v = 32'h7FFFFFFF;
            default: v = 32'h80000001;
          endcase
        end
      endcase
      if (f && $urandom_range(0, 1)) v = -v;
      add_req(f, v);
    end

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("tb: %0d numbers converted (%0d negative), %0d characters checked",
             numbers_done, negatives_done, chars_seen);
    $display("tb: %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
